>>> hw/rtl/crm_pkg.sv
// Shared types and constants for the circle region mean block.
package crm_pkg;

    localparam int PIX_W      = 8;
    localparam int FIELDS     = 3;
    localparam int COORD_W    = 12;
    localparam int CFG_W      = 9;
    localparam int MEAN_W     = 12;
    localparam int COUNT_W    = 17;
    localparam int CH_W       = 2;
    localparam int MIN_INSIDE = 3;
    localparam int SIZE_RESET = 256;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic [PIX_W-1:0]   pixel_row;
        logic [PIX_W-1:0]   pixel_col;
        logic [PIX_W-1:0]   value_ch0;
        logic [PIX_W-1:0]   value_ch1;
        logic [PIX_W-1:0]   value_ch2;
        logic [COORD_W-1:0] center_x;
        logic [COORD_W-1:0] center_y;
        logic [COORD_W-1:0] radius;
    } t_in_item;

    typedef struct packed {
        logic [MEAN_W-1:0]  mean_ch0;
        logic [MEAN_W-1:0]  mean_ch1;
        logic [MEAN_W-1:0]  mean_ch2;
        logic [COUNT_W-1:0] inside_count;
        logic               too_few;
    } t_out_item;

    typedef struct packed {
        logic            accept_wr;
        logic            accept_q;
        logic            setup;
        logic            walk_init;
        logic            walk;
        logic            div_start;
        logic [CH_W-1:0] div_ch;
        logic            load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic box_empty;
        logic walk_last;
        logic div_done;
        logic out_free;
    } t_dp_sts;

endpackage

>>> hw/rtl/crm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module crm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/crm_div.sv
// Restoring divider, one quotient bit per cycle.
module crm_div #(
    parameter int DVD_W = 29,
    parameter int DVS_W = 17
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DVD_W-1:0] r_q, n_q;
    logic [DVS_W-1:0] r_rem, n_rem;
    logic [DVS_W-1:0] r_dvs, n_dvs;
    logic [DVS_W:0]   s_sh;
    logic             s_ge;

    assign s_sh = {r_rem, r_q[DVD_W-1]};
    assign s_ge = (s_sh >= {1'b0, r_dvs});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(DVD_W);
            n_q    = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_q   = {r_q[DVD_W-2:0], s_ge};
            n_rem = s_ge ? DVS_W'(s_sh - {1'b0, r_dvs}) : DVS_W'(s_sh);
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

>>> hw/rtl/crm_ctrl.sv
// Controller state machine: accept, box setup, pixel walk, drain, divide, deliver.
module crm_ctrl import crm_pkg::*; #(
    parameter int NCH = 3
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_req_type,
    input  t_dp_sts i_sts,
    output logic    o_in_stall,
    output t_dp_cmd o_cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SETUP    = 3'd1;
    localparam logic [2:0] S_CHECK    = 3'd2;
    localparam logic [2:0] S_WALK     = 3'd3;
    localparam logic [2:0] S_DRAIN    = 3'd4;
    localparam logic [2:0] S_DIV_GO   = 3'd5;
    localparam logic [2:0] S_DIV_WAIT = 3'd6;
    localparam logic [2:0] S_FINISH   = 3'd7;

    logic [2:0]      r_state, n_state;
    logic [CH_W-1:0] r_ch, n_ch;
    logic [1:0]      r_drain, n_drain;
    logic            s_accept;

    assign s_accept   = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_ch    = r_ch;
        n_drain = r_drain;
        o_cmd   = '0;
        o_cmd.div_ch = r_ch;
        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    if (i_req_type == REQ_QUERY) begin
                        o_cmd.accept_q = 1'b1;
                        n_state = S_SETUP;
                    end else begin
                        o_cmd.accept_wr = 1'b1;
                    end
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_ch = '0;
                if (i_sts.box_empty) begin
                    n_state = S_DIV_GO;
                end else begin
                    o_cmd.walk_init = 1'b1;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_sts.walk_last) begin
                    n_drain = '0;
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // wait for the last pixel to leave the distance pipeline
                n_drain = r_drain + 2'd1;
                if (r_drain == 2'd2) begin
                    n_state = S_DIV_GO;
                end
            end
            S_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_sts.div_done) begin
                    if (r_ch == CH_W'(NCH - 1)) begin
                        n_state = S_FINISH;
                    end else begin
                        n_ch = r_ch + CH_W'(1);
                        n_state = S_DIV_GO;
                    end
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ch    <= '0;
            r_drain <= '0;
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
            r_drain <= n_drain;
        end
    end

endmodule

>>> hw/rtl/crm_dp.sv
// Datapath: pixel store, box bounds, distance pipeline, accumulators, divider, result register.
module crm_dp import crm_pkg::*; #(
    parameter int MAX_ROWS  = 256,
    parameter int MAX_COLS  = 256,
    parameter int NCH       = 3,
    parameter int FRAC_BITS = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_in_item         i_in_item,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  t_dp_cmd          i_cmd,
    output t_dp_sts          o_sts,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_item
);

    localparam int NPIX  = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(NPIX);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int CNT_W = $clog2(NPIX + 1);
    localparam int SUM_W = PIX_W + CNT_W;
    localparam int DVD_W = SUM_W + FRAC_BITS;
    localparam int BOX_W = COORD_W + 2;
    localparam int POS_W = COORD_W + 1;
    localparam int DIF_W = COORD_W + 3;
    localparam int SQ_W  = 2 * DIF_W - 2;
    localparam int LIM_W = 2 * COORD_W + 1;
    localparam int RAM_W = NCH * PIX_W;

    // configuration
    logic [CFG_W-1:0] r_image_rows, r_image_cols;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_rows <= CFG_W'(SIZE_RESET);
            r_image_cols <= CFG_W'(SIZE_RESET);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_ROWS) begin
                r_image_rows <= i_cfg_wdata;
            end else begin
                r_image_cols <= i_cfg_wdata;
            end
        end
    end

    // query operands
    logic [COORD_W-1:0] r_cx, r_cy, r_r;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_q) begin
            r_cx <= i_in_item.center_x;
            r_cy <= i_in_item.center_y;
            r_r  <= i_in_item.radius;
        end
    end

    // bounding box, clamped to the image in use
    logic [COORD_W:0]         s_xsum, s_ysum;
    logic [BOX_W-1:0]         s_ncols, s_nrows;
    logic signed [BOX_W-1:0]  s_lastc, s_lastr;
    logic signed [BOX_W-1:0]  s_minc, s_maxc, s_minr, s_maxr;
    logic signed [BOX_W-1:0]  r_min_col, r_max_col, r_min_row, r_max_row;
    logic [LIM_W-1:0]         r_limit;

    assign s_xsum  = {1'b0, r_cx} + {1'b0, r_r};
    assign s_ysum  = {1'b0, r_cy} + {1'b0, r_r};
    assign s_ncols = (BOX_W'(r_image_cols) > BOX_W'(MAX_COLS)) ? BOX_W'(MAX_COLS)
                                                                 : BOX_W'(r_image_cols);
    assign s_nrows = (BOX_W'(r_image_rows) > BOX_W'(MAX_ROWS)) ? BOX_W'(MAX_ROWS)
                                                                 : BOX_W'(r_image_rows);
    assign s_lastc = $signed(s_ncols) - BOX_W'(1);
    assign s_lastr = $signed(s_nrows) - BOX_W'(1);

    always_comb begin
        s_minc = (r_cx >= r_r) ? $signed(BOX_W'((r_cx - r_r) >> FRAC_BITS)) : '0;
        s_minr = (r_cy >= r_r) ? $signed(BOX_W'((r_cy - r_r) >> FRAC_BITS)) : '0;
        s_maxc = $signed(BOX_W'(s_xsum >> FRAC_BITS));
        s_maxr = $signed(BOX_W'(s_ysum >> FRAC_BITS));
        if (s_maxc > s_lastc) begin
            s_maxc = s_lastc;
        end
        if (s_maxr > s_lastr) begin
            s_maxr = s_lastr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_min_col <= s_minc;
            r_max_col <= s_maxc;
            r_min_row <= s_minr;
            r_max_row <= s_maxr;
            r_limit   <= LIM_W'(r_r) * LIM_W'(r_r)
                         + (LIM_W'(1) << (2 * FRAC_BITS - 2));
        end
    end

    assign o_sts.box_empty = (r_min_col > r_max_col) || (r_min_row > r_max_row);

    // walk counters
    logic [POS_W-1:0] r_row, r_col;
    logic             s_col_end;

    assign s_col_end       = (r_col == r_max_col[POS_W-1:0]);
    assign o_sts.walk_last = s_col_end && (r_row == r_max_row[POS_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_init) begin
            r_row <= r_min_row[POS_W-1:0];
            r_col <= r_min_col[POS_W-1:0];
        end else if (i_cmd.walk) begin
            if (s_col_end) begin
                r_col <= r_min_col[POS_W-1:0];
                r_row <= r_row + POS_W'(1);
            end else begin
                r_col <= r_col + POS_W'(1);
            end
        end
    end

    // pixel store
    logic [AW-1:0]    s_waddr, s_raddr;
    logic [RAM_W-1:0] s_wdata, s_rdata;
    logic             s_wr_ok;
    logic [PIX_W-1:0] s_vals [FIELDS];

    assign s_vals[0] = i_in_item.value_ch0;
    assign s_vals[1] = i_in_item.value_ch1;
    assign s_vals[2] = i_in_item.value_ch2;

    for (genvar j = 0; j < NCH; j++) begin : g_wdata
        assign s_wdata[j*PIX_W +: PIX_W] = s_vals[j];
    end

    // drop writes that fall outside the store
    assign s_wr_ok = (BOX_W'(i_in_item.pixel_row) < BOX_W'(MAX_ROWS))
                  && (BOX_W'(i_in_item.pixel_col) < BOX_W'(MAX_COLS));
    assign s_waddr = AW'(i_in_item.pixel_row) * AW'(MAX_COLS) + AW'(i_in_item.pixel_col);
    assign s_raddr = AW'(r_row[RW-1:0]) * AW'(MAX_COLS) + AW'(r_col[CW-1:0]);

    crm_ram #(
        .WIDTH (RAM_W),
        .DEPTH (NPIX)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accept_wr && s_wr_ok),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    // distance pipeline: offsets, squares, compare and accumulate
    logic                    r_a_vld, r_b_vld;
    logic signed [DIF_W-1:0] r_a_dx, r_a_dy;
    logic signed [SQ_W-1:0]  s_dxw, s_dyw;
    logic [SQ_W-1:0]         r_b_dx2, r_b_dy2;
    logic [RAM_W-1:0]        r_b_pix;
    logic                    s_inside;

    assign s_dxw = SQ_W'(r_a_dx);
    assign s_dyw = SQ_W'(r_a_dy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            r_a_vld <= i_cmd.walk;
            r_b_vld <= r_a_vld;
        end
        r_a_dx  <= $signed((DIF_W'(r_col) << FRAC_BITS) - DIF_W'(r_cx));
        r_a_dy  <= $signed((DIF_W'(r_row) << FRAC_BITS) - DIF_W'(r_cy));
        r_b_dx2 <= s_dxw * s_dxw;
        r_b_dy2 <= s_dyw * s_dyw;
        r_b_pix <= s_rdata;
    end

    assign s_inside = ({1'b0, r_b_dx2} + {1'b0, r_b_dy2}) < (SQ_W + 1)'(r_limit);

    logic [SUM_W-1:0] r_sum [FIELDS];
    logic [CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_count <= '0;
        end else if (r_b_vld && s_inside) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    for (genvar j = 0; j < FIELDS; j++) begin : g_sum
        if (j < NCH) begin : g_used
            always_ff @(posedge i_clk) begin
                if (i_cmd.setup) begin
                    r_sum[j] <= '0;
                end else if (r_b_vld && s_inside) begin
                    r_sum[j] <= r_sum[j] + SUM_W'(r_b_pix[j*PIX_W +: PIX_W]);
                end
            end
        end else begin : g_unused
            assign r_sum[j] = '0;
        end
    end

    // per-channel mean through the shared divider
    logic [DVD_W-1:0]  s_quot;
    logic              s_div_done;
    logic [CH_W-1:0]   r_div_ch;
    logic [MEAN_W-1:0] r_mean [FIELDS];

    crm_div #(
        .DVD_W (DVD_W),
        .DVS_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (DVD_W'(r_sum[i_cmd.div_ch]) << FRAC_BITS),
        .i_divisor  (r_count),
        .o_done     (s_div_done),
        .o_quotient (s_quot)
    );

    assign o_sts.div_done = s_div_done;

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_div_ch <= i_cmd.div_ch;
        end
        if (s_div_done) begin
            r_mean[r_div_ch] <= s_quot[MEAN_W-1:0];
        end
    end

    // result register
    logic              r_out_valid;
    t_out_item         r_out_item;
    logic [MEAN_W-1:0] s_mean [FIELDS];

    for (genvar j = 0; j < FIELDS; j++) begin : g_mean
        if (j < NCH) begin : g_used
            assign s_mean[j] = (r_count == '0) ? '0 : r_mean[j];
        end else begin : g_unused
            assign s_mean[j] = '0;
        end
    end

    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.load_out) begin
            r_out_item.mean_ch0     <= s_mean[0];
            r_out_item.mean_ch1     <= s_mean[1];
            r_out_item.mean_ch2     <= s_mean[2];
            r_out_item.inside_count <= COUNT_W'(r_count);
            r_out_item.too_few      <= (r_count < CNT_W'(MIN_INSIDE));
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

>>> hw/rtl/circle_region_mean.sv
// Top level of the circle region mean block: controller and datapath.
//
//  channel | direction | handshake              | payload
//  in      | input     | i_in_valid / o_in_stall | i_in_item  (t_in_item)
//  out     | output    | o_out_valid / i_out_stall | o_out_item (t_out_item)
//  cfg     | input     | i_cfg_we               | i_cfg_idx, i_cfg_wdata
//
// A pixel write does not stall the input. A query walks the clamped bounding box one pixel
// per cycle through the single read port of the pixel store, then divides each channel sum
// in turn in the bit-serial divider, whose dividend width is 29 at the default sizes.
// Reset is synchronous and active low; it sets both image sizes to 256 and leaves the
// pixel store undefined. A finished result waits in the output register while stalled;
// the next write can be taken meanwhile, and a query finishes only when that register frees.
module circle_region_mean import crm_pkg::*; #(
    parameter int MAX_ROWS  = 256,
    parameter int MAX_COLS  = 256,
    parameter int CHANNELS  = 3,
    parameter int FRAC_BITS = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_item,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    localparam int NCH = (CHANNELS < FIELDS) ? CHANNELS : FIELDS;

    t_dp_cmd s_cmd;
    t_dp_sts s_sts;

    crm_ctrl #(
        .NCH (NCH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_in_item.req_type),
        .i_sts      (s_sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (s_cmd)
    );

    crm_dp #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_COLS  (MAX_COLS),
        .NCH       (NCH),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (s_cmd),
        .o_sts       (s_sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

>>> hw/rtl/crm_checker.sv
// Port-level checks for the circle region mean block, bound to the top level.
module crm_checker import crm_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    // a stalled result transaction stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_too_few: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.too_few
                         == (o_out_item.inside_count < COUNT_W'(MIN_INSIDE))))
        else $error("too_few disagrees with inside_count");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled after reset");

endmodule

bind circle_region_mean crm_checker u_crm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
